// ----- src/lmebd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the list-mode event buffer decoder.
// No dependencies; every other file imports this package.
package lmebd_pkg;

    localparam int BUFFER_WORDS_MAX = 131072;
    localparam int BUF_LEFT_W       = $clog2(BUFFER_WORDS_MAX);

    localparam logic [15:0] SAT_ENERGY_RESET = 16'd16383;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int TDATA_W = 136;

    typedef enum logic [2:0] {
        KIND_EVENT  = 3'd0,
        KIND_TRACE  = 3'd1,
        KIND_DONE   = 3'd2,
        KIND_LENERR = 3'd3,
        KIND_BADHDR = 3'd4,
        KIND_BADEVT = 3'd5
    } kind_t;

    typedef enum logic [5:0] {
        PH_LEN    = 6'b000001,
        PH_MODULE = 6'b000010,
        PH_HEADER = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_TRACE  = 6'b010000,
        PH_DROP   = 6'b100000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  channel;
        logic [15:0] module_res;
        logic [15:0] energy;
        logic [47:0] event_time;
        logic [15:0] cfd_time;
        logic        pileup;
        logic        saturated;
        logic        virtual_channel;
        logic [15:0] sample_first;
        logic [15:0] sample_second;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               ready;
    } q_status_t;

endpackage

// ----- src/lmebd_decode.sv -----
`timescale 1ns / 1ps
// Buffer and event header decoder: parse state plus per-word result build.
// Depends on lmebd_pkg.
module lmebd_decode
    import lmebd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [31:0] data_word,
    input  logic [15:0] saturated_energy,
    output push_t       push
);

    phase_t                phase_reg, phase_next;
    logic [BUF_LEFT_W-1:0] buf_left_reg, buf_left_next;
    logic [15:0]           buf_module_reg, buf_module_next;
    logic [1:0]            word_in_event_reg, word_in_event_next;
    logic [4:0]            header_length_reg, header_length_next;
    logic [11:0]           event_length_reg, event_length_next;
    logic [14:0]           trace_left_reg, trace_left_next;
    logic [11:0]           skip_left_reg, skip_left_next;

    logic [3:0]            hdr_channel_reg, hdr_channel_next;
    logic [3:0]            hdr_crate_reg, hdr_crate_next;
    logic [2:0]            hdr_flags_reg, hdr_flags_next;
    logic [31:0]           low_time_reg, low_time_next;
    logic [31:0]           time_cfd_reg, time_cfd_next;

    function automatic phase_t phase_after(input logic [11:0] skip, input logic [14:0] trace);
        phase_t p;
        if (skip != 12'd0)
        begin
            p = PH_SKIP;
        end
        else if (trace != 15'd0)
        begin
            p = PH_TRACE;
        end
        else
        begin
            p = PH_HEADER;
        end
        return p;
    endfunction

    always_comb
    begin
        result_t     first;
        result_t     done_res;
        logic        has_first;
        logic        has_done;
        logic [4:0]  hl;
        logic [11:0] el;
        logic [14:0] trace_half;
        logic [15:0] len_sum;

        phase_next         = phase_reg;
        buf_left_next      = buf_left_reg;
        buf_module_next    = buf_module_reg;
        word_in_event_next = word_in_event_reg;
        header_length_next = header_length_reg;
        event_length_next  = event_length_reg;
        trace_left_next    = trace_left_reg;
        skip_left_next     = skip_left_reg;
        hdr_channel_next   = hdr_channel_reg;
        hdr_crate_next     = hdr_crate_reg;
        hdr_flags_next     = hdr_flags_reg;
        low_time_next      = low_time_reg;
        time_cfd_next      = time_cfd_reg;

        first       = '0;
        done_res    = '0;
        done_res.kind = KIND_DONE;
        has_first   = 1'b0;
        has_done    = 1'b0;
        hl          = data_word[16:12];
        el          = data_word[28:17];
        trace_half  = data_word[31:17];
        len_sum     = {1'b0, trace_half} + 16'(header_length_reg);

        if (phase_reg == PH_LEN)
        begin
            if (data_word == 32'd0 || data_word > 32'(BUFFER_WORDS_MAX))
            begin
                has_first  = 1'b1;
                first.kind = KIND_LENERR;
            end
            else if (data_word == 32'd1)
            begin
                has_done = 1'b1;
            end
            else
            begin
                buf_left_next = BUF_LEFT_W'(data_word - 32'd1);
                phase_next    = PH_MODULE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_MODULE:
                begin
                    buf_module_next    = data_word[15:0];
                    word_in_event_next = 2'd0;
                    phase_next         = PH_HEADER;
                end
                PH_HEADER:
                begin
                    unique case (word_in_event_reg)
                        2'd0:
                        begin
                            hdr_channel_next   = data_word[3:0];
                            hdr_crate_next     = data_word[11:8];
                            hdr_flags_next     = data_word[31:29];
                            header_length_next = hl;
                            event_length_next  = el;
                            if (hl == 5'd1)
                            begin
                                skip_left_next  = (el > 12'd1) ? el - 12'd1 : 12'd0;
                                trace_left_next = 15'd0;
                                phase_next      = phase_after(skip_left_next, 15'd0);
                            end
                            else if (hl != 5'd4 && hl != 5'd8 && hl != 5'd12 && hl != 5'd16)
                            begin
                                has_first  = 1'b1;
                                first.kind = KIND_BADHDR;
                                phase_next = PH_DROP;
                            end
                            else
                            begin
                                word_in_event_next = 2'd1;
                            end
                        end
                        2'd1:
                        begin
                            low_time_next      = data_word;
                            word_in_event_next = 2'd2;
                        end
                        2'd2:
                        begin
                            time_cfd_next      = data_word;
                            word_in_event_next = 2'd3;
                        end
                        default:
                        begin
                            word_in_event_next = 2'd0;
                            has_first          = 1'b1;
                            if (len_sum != 16'(event_length_reg))
                            begin
                                first.kind      = KIND_BADEVT;
                                skip_left_next  = (event_length_reg > 12'd4) ?
                                                  event_length_reg - 12'd4 : 12'd0;
                                trace_left_next = 15'd0;
                            end
                            else
                            begin
                                first.kind            = KIND_EVENT;
                                first.channel         = hdr_channel_reg;
                                first.module_res      = buf_module_reg +
                                                        16'(hdr_crate_reg * 11'd100);
                                first.saturated       = hdr_flags_reg[1];
                                first.energy          = hdr_flags_reg[1] ? saturated_energy
                                                                         : data_word[15:0];
                                first.event_time      = {time_cfd_reg[15:0], low_time_reg};
                                first.cfd_time        = time_cfd_reg[31:16];
                                first.pileup          = hdr_flags_reg[2];
                                first.virtual_channel = hdr_flags_reg[0];
                                skip_left_next        = 12'(header_length_reg - 5'd4);
                                trace_left_next       = trace_half;
                            end
                            phase_next = phase_after(skip_left_next, trace_left_next);
                        end
                    endcase
                end
                PH_SKIP:
                begin
                    if (skip_left_reg != 12'd0)
                    begin
                        skip_left_next = skip_left_reg - 12'd1;
                    end
                    if (skip_left_next == 12'd0)
                    begin
                        phase_next = (trace_left_reg != 15'd0) ? PH_TRACE : PH_HEADER;
                    end
                end
                PH_TRACE:
                begin
                    has_first           = 1'b1;
                    first.kind          = KIND_TRACE;
                    first.sample_first  = data_word[15:0];
                    first.sample_second = data_word[31:16];
                    if (trace_left_reg != 15'd0)
                    begin
                        trace_left_next = trace_left_reg - 15'd1;
                    end
                    if (trace_left_next == 15'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (buf_left_reg != '0)
            begin
                buf_left_next = buf_left_reg - BUF_LEFT_W'(1);
            end
            if (buf_left_next == '0)
            begin
                has_done           = 1'b1;
                phase_next         = PH_LEN;
                word_in_event_next = 2'd0;
                skip_left_next     = 12'd0;
                trace_left_next    = 15'd0;
            end
        end

        push = '0;
        if (has_first)
        begin
            push.first = first;
            if (has_done)
            begin
                push.second      = done_res;
                push.second.last = 1'b1;
                push.count       = accept ? 2'd2 : 2'd0;
            end
            else
            begin
                push.first.last = 1'b1;
                push.count      = accept ? 2'd1 : 2'd0;
            end
        end
        else if (has_done)
        begin
            push.first      = done_res;
            push.first.last = 1'b1;
            push.count      = accept ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEN;
            buf_left_reg      <= '0;
            buf_module_reg    <= '0;
            word_in_event_reg <= '0;
            header_length_reg <= '0;
            event_length_reg  <= '0;
            trace_left_reg    <= '0;
            skip_left_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            buf_left_reg      <= buf_left_next;
            buf_module_reg    <= buf_module_next;
            word_in_event_reg <= word_in_event_next;
            header_length_reg <= header_length_next;
            event_length_reg  <= event_length_next;
            trace_left_reg    <= trace_left_next;
            skip_left_reg     <= skip_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_channel_reg <= hdr_channel_next;
            hdr_crate_reg   <= hdr_crate_next;
            hdr_flags_reg   <= hdr_flags_next;
            low_time_reg    <= low_time_next;
            time_cfd_reg    <= time_cfd_next;
        end
    end

endmodule

// ----- src/lmebd_result_queue.sv -----
`timescale 1ns / 1ps
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on lmebd_pkg.
module lmebd_result_queue
    import lmebd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    input  logic      pop_ready,
    output logic      head_valid,
    output result_t   head,
    output q_status_t status
);

    result_t            entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               pop;

    assign head_valid   = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = head_valid && pop_ready;
    assign status.count = count_reg;
    assign status.ready = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + Q_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ----- src/list_mode_event_buffer_decoder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the list-mode event buffer decoder: ports, energy register.
// Depends on lmebd_pkg, lmebd_decode and lmebd_result_queue.

// Takes a digitizer module buffer one 32-bit word per item on the slave side
// and emits event, trace-pair, buffer-done and error results on the master
// side. Each word is decoded in the cycle it is accepted, so one word can be
// taken every cycle while the queue has room. Results leave one per cycle
// from a four-entry queue while m_tready is high; the input is ready while
// two entries are free. The last word of a buffer that also carries its own
// result yields two results, and under a steady run of such words the queue
// sets the rate. Write cfg_wdata with cfg_we only while the block is idle.
module list_mode_event_buffer_decoder_unit
    import lmebd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,     // saturated_energy
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,       // data_word
    output logic               m_tvalid,
    input  logic               m_tready,
    // channel, module_res, energy, event_time, cfd_time, pileup, saturated,
    // virtual_channel, sample_first, sample_second, zero pad
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser,       // kind
    output logic               m_tlast        // last
);

    logic [15:0] saturated_energy_reg;
    logic        accept;
    logic        pop;
    push_t       push;
    result_t     head;
    q_status_t   q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturated_energy_reg <= SAT_ENERGY_RESET;
        end
        else if (cfg_we)
        begin
            saturated_energy_reg <= cfg_wdata;
        end
    end

    assign s_tready = q_status.ready;
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    lmebd_decode u_decode (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .data_word        (s_tdata),
        .saturated_energy (saturated_energy_reg),
        .push             (push)
    );

    lmebd_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head       (head),
        .status     (q_status)
    );

    assign m_tdata = {1'b0, head.sample_second, head.sample_first, head.virtual_channel,
                      head.saturated, head.pileup, head.cfd_time, head.event_time,
                      head.energy, head.module_res, head.channel};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

`ifndef SYNTHESIS
    a_double_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept && push.count == 2'd2 && !pop |=> q_status.count == $past(q_status.count) + 3'd2)
        else $error("two results pushed but queue occupancy did not grow by two");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_DONE |-> m_tlast)
        else $error("buffer done result without last");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> q_status.count <= 3'(Q_DEPTH - 2))
        else $error("results pushed with fewer than two free queue entries");
`endif

endmodule
